@@ rtl/core/czi_pkg.sv @@
package czi_pkg;

  localparam int MAX_WINDOW_WIDTH = 1024;
  localparam int LB_AW            = $clog2(MAX_WINDOW_WIDTH);
  localparam int CNT_W            = 12;
  localparam int WW_W             = 11;
  localparam int PIX_W            = 8;
  localparam int ROW_W            = 13;
  localparam int COL_W            = 11;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 12;
  localparam int OUT_DATA_W       = ROW_W + COL_W + PIX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_WINDOW_TOP    = 3'd1,
    CFG_WINDOW_LEFT   = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_WINDOW_WIDTH  = 3'd4
  } cfg_idx_t;

  // truncated mean of two pixels
  function automatic logic [PIX_W-1:0] mean2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W:1];
  endfunction

endpackage

@@ rtl/core/crop_and_zoom_2x_interpolator.sv @@
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-----------------------------------------
// in_      | input     | in_tvalid/in_tready | tdata: pixel_in, tuser: frame_start
// out_     | output    | out_tvalid/tready   | tdata: out_row,out_col,pixel_out; tlast
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// one result leaves per cycle while out_tready is high; an in-window pixel holds the input
// until it has issued its 1 to 4 results, a pixel outside the window makes no result.
// the line buffer is a single-port read-old ram: read and update in the accept cycle.
// after reset a clearing pass zeroes all MAX_WINDOW_WIDTH (1024) line buffer entries
// with in_tready low; configuration writes are taken meanwhile.
// out_tready low holds the output register and, once the pending results wait,
// the input side.
module crop_and_zoom_2x_interpolator
  import czi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [12:0] out_row, [23:13] out_col, [31:24] pixel_out
  output logic                  out_tlast,  // run_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [CNT_W-1:0] src_width_r, win_top_r, win_left_r, win_height_r;
  logic [WW_W-1:0]  win_width_r;

  // position counters
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;

  // line buffer clearing
  logic             clr_busy_r;
  logic [LB_AW-1:0] clr_cnt_r;

  // line buffer
  logic [PIX_W-1:0] lbuf [MAX_WINDOW_WIDTH];
  logic             mem_we, mem_re;
  logic [LB_AW-1:0] mem_addr;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] up_r;

  // work stage
  logic [3:0]       pend_r, pend_nxt;
  logic [PIX_W-1:0] b_pix_r, b_left_r;
  logic [CNT_W-1:0] b_row_r;
  logic [LB_AW-1:0] b_col_r;
  logic [PIX_W-1:0] left_pix_r, upleft_pix_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic             in_acc, in_win, issue, last;
  logic [CNT_W-1:0] row_cur, col_cur, r_off, c_off;
  logic [WW_W-1:0]  width_eff;
  logic [CNT_W:0]   col_inc;
  logic [3:0]       mask;
  logic [3:0]       rest;
  logic [ROW_W-1:0] row_even, row_odd, res_row;
  logic [COL_W-1:0] col_even, col_odd, res_col;
  logic [PIX_W-1:0] res_pix;

  assign cfg_ready = 1'b1;

  // window test and counter advance for the incoming pixel
  always_comb begin
    row_cur   = in_tuser ? '0 : row_cnt_r;
    col_cur   = in_tuser ? '0 : col_cnt_r;
    width_eff = (int'(win_width_r) > MAX_WINDOW_WIDTH) ? WW_W'(MAX_WINDOW_WIDTH) : win_width_r;
    r_off     = row_cur - win_top_r;
    c_off     = col_cur - win_left_r;
    in_win    = (row_cur >= win_top_r) && (col_cur >= win_left_r) &&
                (r_off < win_height_r) && ({1'b0, c_off} < {2'b00, width_eff});
    col_inc   = {1'b0, col_cur} + 1'b1;
    if (col_inc >= {1'b0, src_width_r} || col_inc[CNT_W]) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = row_cur + 1'b1;
    end else begin
      col_cnt_nxt = col_inc[CNT_W-1:0];
      row_cnt_nxt = row_cur;
    end
    // bit 0 first: (2r-1,2c-1), (2r-1,2c), (2r,2c-1), (2r,2c)
    mask = {1'b1, c_off != '0, r_off != '0, (r_off != '0) && (c_off != '0)};
  end

  // result selection from the pending set, lowest bit first
  always_comb begin
    rest     = pend_r & (pend_r - 1'b1);
    last     = (rest == '0);
    issue    = (pend_r != '0) && (!out_valid_r || out_tready);
    pend_nxt = issue ? rest : pend_r;
    row_even = {b_row_r, 1'b0};
    row_odd  = row_even - 1'b1;
    col_even = COL_W'({b_col_r, 1'b0});
    col_odd  = col_even - 1'b1;
    if (pend_r[0]) begin
      res_row = row_odd;
      res_col = col_odd;
      res_pix = mean2(mean2(upleft_pix_r, up_r), mean2(b_left_r, b_pix_r));
    end else if (pend_r[1]) begin
      res_row = row_odd;
      res_col = col_even;
      res_pix = mean2(up_r, b_pix_r);
    end else if (pend_r[2]) begin
      res_row = row_even;
      res_col = col_odd;
      res_pix = mean2(b_left_r, b_pix_r);
    end else begin
      res_row = row_even;
      res_col = col_even;
      res_pix = b_pix_r;
    end
  end

  assign in_tready = !clr_busy_r && ((pend_r == '0) || (issue && last));
  assign in_acc    = in_tvalid && in_tready;

  assign mem_re    = in_acc && in_win;
  assign mem_we    = clr_busy_r || mem_re;
  assign mem_addr  = clr_busy_r ? clr_cnt_r : c_off[LB_AW-1:0];
  assign mem_wdata = clr_busy_r ? '0 : in_tdata;

  // read returns the old entry when it is overwritten in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) lbuf[mem_addr] <= mem_wdata;
    if (mem_re) up_r <= lbuf[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= CNT_W'(1);
      win_top_r    <= '0;
      win_left_r   <= '0;
      win_height_r <= CNT_W'(1);
      win_width_r  <= WW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SOURCE_WIDTH:  src_width_r  <= cfg_data;
        CFG_WINDOW_TOP:    win_top_r    <= cfg_data;
        CFG_WINDOW_LEFT:   win_left_r   <= cfg_data;
        CFG_WINDOW_HEIGHT: win_height_r <= cfg_data;
        CFG_WINDOW_WIDTH:  win_width_r  <= cfg_data[WW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      pend_r       <= '0;
      left_pix_r   <= '0;
      upleft_pix_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LB_AW'(MAX_WINDOW_WIDTH - 1)) clr_busy_r <= 1'b0;
      end
      // the upper-left pixel of the next item is this item's upper pixel
      if (issue && last) upleft_pix_r <= up_r;
      pend_r <= pend_nxt;
      if (in_acc) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
        if (in_win) begin
          pend_r     <= mask;
          left_pix_r <= in_tdata;
        end
      end
      if (issue) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      b_pix_r  <= in_tdata;
      b_left_r <= left_pix_r;
      b_row_r  <= r_off;
      b_col_r  <= c_off[LB_AW-1:0];
    end
    if (issue) begin
      out_data_r <= {res_pix, res_col, res_row};
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // the original pixel is always the final pending result
  a_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> pend_r[3])
    else $error("pending set lost its final result");

  a_load_window: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_win) |=> pend_r[3])
    else $error("in-window pixel did not load the work stage");

  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!out_valid_r && pend_r == '0))
    else $error("result present during line buffer clear");

  a_last_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (!out_tdata[0] && !out_tdata[ROW_W]))
    else $error("final result of a pixel not at even coordinates");

  a_win_sets_left: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_win) |=> (left_pix_r == $past(in_tdata)))
    else $error("left pixel not updated");

endmodule
